// File: rtl/key_matrix_midi_note_events_top_assert.svh
// Assertion macros for the key matrix MIDI note event block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef KEY_MATRIX_MIDI_NOTE_EVENTS_TOP_ASSERT_SVH
`define KEY_MATRIX_MIDI_NOTE_EVENTS_TOP_ASSERT_SVH

// Same-cycle implication, off during reset.
`define KMME_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define KMME_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kmme_pkg.sv
// Shared types and constants for the key matrix MIDI note event block.
// No dependencies.
`default_nettype none

package kmme_pkg;

    localparam int ROW_LINES = 4;   // row inputs per column
    localparam int COL_OFF_W = 4;   // note offset of a column within a row, 0..15
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int JOB_Q_DEPTH = 2;

    localparam logic [3:0] MIDI_NOTE_ON = 4'h9;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_NOTE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_VELOCITY = 2'd2;

    localparam logic [3:0] RST_MIDI_CHANNEL = 4'd1;
    localparam logic [6:0] RST_LOWEST_NOTE = 7'd41;
    localparam logic [6:0] RST_PRESS_VELOCITY = 7'd127;

    typedef struct packed {
        logic [3:0] midi_channel;
        logic [6:0] lowest_note;
        logic [6:0] press_velocity;
    } cfg_t;

    // One column's worth of key changes
    typedef struct packed {
        logic [COL_OFF_W-1:0] col_off;
        logic [ROW_LINES-1:0] press;
        logic [ROW_LINES-1:0] release_m;
    } job_t;

    // Index of the lowest set bit (0 for an empty mask)
    function automatic logic [1:0] lowest_set(input logic [ROW_LINES-1:0] m);
        logic [1:0] idx;
        idx = 2'd0;
        for (int i = ROW_LINES - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = 2'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: rtl/kmme_col_if.sv
// Column scan channel: column index and row levels.
// Depends on nothing.
`default_nettype none

interface kmme_col_if;
    logic       valid;
    logic       ready;
    logic [2:0] column_index;
    logic [3:0] row_levels;

    modport source (output valid, output column_index, output row_levels, input ready);
    modport sink (input valid, input column_index, input row_levels, output ready);
endinterface

`default_nettype wire

// File: rtl/kmme_midi_if.sv
// MIDI byte channel: one message byte per item, with end-of-column flag.
// Depends on nothing.
`default_nettype none

interface kmme_midi_if;
    logic       valid;
    logic       ready;
    logic [7:0] midi_byte;
    logic       last_byte;

    modport source (output valid, output midi_byte, output last_byte, input ready);
    modport sink (input valid, input midi_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/kmme_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on kmme_pkg for widths.
`default_nettype none

interface kmme_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [kmme_pkg::CFG_IDX_W-1:0]  index;
    logic [kmme_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/kmme_front.sv
// Front end: accepts scanned columns, keeps the pressed-key map, and
// queues the press/release masks of each changed column. Uses kmme_pkg.
`default_nettype none

module kmme_front #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    kmme_col_if.sink          col,
    input  wire logic         q_full,
    output logic              q_push,
    output kmme_pkg::job_t    q_job
);

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int MAP_ROWS = (NUM_ROWS < kmme_pkg::ROW_LINES) ? NUM_ROWS
                                                               : kmme_pkg::ROW_LINES;
    localparam logic [kmme_pkg::ROW_LINES-1:0] ROW_EN =
        kmme_pkg::ROW_LINES'((1 << MAP_ROWS) - 1);

    logic [MAP_ROWS-1:0] map_reg [NUM_COLUMNS];

    logic                           accept;
    logic                           col_ok;
    logic [COL_W-1:0]               col_idx;
    logic [kmme_pkg::ROW_LINES-1:0] map_col;
    logic [kmme_pkg::ROW_LINES-1:0] press;
    logic [kmme_pkg::ROW_LINES-1:0] release_m;

    assign col.ready = !q_full;
    assign accept    = col.valid && col.ready;
    assign col_ok    = 32'(col.column_index) < 32'(NUM_COLUMNS);
    assign col_idx   = COL_W'(col.column_index);
    assign map_col   = kmme_pkg::ROW_LINES'(map_reg[col_idx]);
    assign press     = col.row_levels & ~map_col & ROW_EN;
    assign release_m = ~col.row_levels & map_col;

    assign q_push = accept && col_ok && ((press | release_m) != '0);

    always_comb
    begin
        q_job.press     = press;
        q_job.release_m = release_m;
        if (col.column_index == 3'd0)
        begin
            q_job.col_off = kmme_pkg::COL_OFF_W'(NUM_COLUMNS - 1);
        end
        else
        begin
            q_job.col_off = kmme_pkg::COL_OFF_W'(col.column_index) - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLUMNS; c++)
            begin
                map_reg[c] <= '0;
            end
        end
        else if (accept && col_ok)
        begin
            map_reg[col_idx] <= MAP_ROWS'(map_col ^ (press | release_m));
        end
    end

endmodule

`default_nettype wire

// File: rtl/kmme_job_fifo.sv
// Short job queue between front and back ends.
// Uses kmme_pkg for the job type and depth.
`default_nettype none

module kmme_job_fifo (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  kmme_pkg::job_t  push_job,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output kmme_pkg::job_t  head_job
);

    localparam int DEPTH = kmme_pkg::JOB_Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kmme_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head_job  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kmme_back.sv
// Back end: turns one queued job into note-on messages, one byte per
// cycle while midi.ready is high, through a registered output stage. Uses kmme_pkg.
`default_nettype none

module kmme_back #(
    parameter int NUM_COLUMNS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  kmme_pkg::cfg_t  cfg_regs,
    input  wire logic       q_valid,
    input  kmme_pkg::job_t  q_job,
    output logic            q_pop,
    kmme_midi_if.source     midi
);

    typedef enum logic [2:0] {
        PH_STATUS = 3'b001,
        PH_NOTE   = 3'b010,
        PH_VEL    = 3'b100
    } phase_t;

    localparam logic [6:0] ROW_STEP = 7'(NUM_COLUMNS);

    phase_t                         phase_reg, phase_next;
    logic                           active_reg, active_next;
    logic [kmme_pkg::COL_OFF_W-1:0] col_off_reg, col_off_next;
    logic [kmme_pkg::ROW_LINES-1:0] press_reg, press_next;
    logic [kmme_pkg::ROW_LINES-1:0] rel_reg, rel_next;
    logic                           outv_reg, outv_next;
    logic [7:0]                     byte_reg, byte_next;
    logic                           last_reg, last_next;

    logic                           adv;
    logic                           use_press;
    logic [kmme_pkg::ROW_LINES-1:0] sel_mask;
    logic [kmme_pkg::ROW_LINES-1:0] low_bit;
    logic [kmme_pkg::ROW_LINES-1:0] rem_press, rem_rel;
    logic                           msg_last;
    logic [1:0]                     row;
    logic [6:0]                     note;
    logic                           job_done;

    assign adv       = active_reg && (!outv_reg || midi.ready);
    assign use_press = press_reg != '0;
    assign sel_mask  = use_press ? press_reg : rel_reg;
    assign low_bit   = sel_mask & (~sel_mask + 1'b1);
    assign rem_press = use_press ? (press_reg & ~low_bit) : press_reg;
    assign rem_rel   = use_press ? rel_reg : (rel_reg & ~low_bit);
    assign msg_last  = (rem_press | rem_rel) == '0;
    assign row       = kmme_pkg::lowest_set(sel_mask);
    assign note      = cfg_regs.lowest_note + 7'(col_off_reg) + ROW_STEP * {5'd0, row};
    assign job_done  = adv && (phase_reg == PH_VEL) && msg_last;
    assign q_pop     = q_valid && (!active_reg || job_done);

    assign midi.valid     = outv_reg;
    assign midi.midi_byte = byte_reg;
    assign midi.last_byte = last_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        active_next  = active_reg;
        col_off_next = col_off_reg;
        press_next   = press_reg;
        rel_next     = rel_reg;
        outv_next    = outv_reg && !midi.ready;
        byte_next    = byte_reg;
        last_next    = last_reg;

        if (adv)
        begin
            outv_next = 1'b1;
            last_next = 1'b0;
            case (phase_reg)
                PH_STATUS:
                begin
                    byte_next  = {kmme_pkg::MIDI_NOTE_ON, cfg_regs.midi_channel};
                    phase_next = PH_NOTE;
                end
                PH_NOTE:
                begin
                    byte_next  = {1'b0, note};
                    phase_next = PH_VEL;
                end
                PH_VEL:
                begin
                    byte_next   = {1'b0, use_press ? cfg_regs.press_velocity : 7'd0};
                    last_next   = msg_last;
                    press_next  = rem_press;
                    rel_next    = rem_rel;
                    phase_next  = PH_STATUS;
                    active_next = !msg_last;
                end
                default:
                begin
                    phase_next = PH_STATUS;
                end
            endcase
        end

        if (q_pop)
        begin
            active_next  = 1'b1;
            phase_next   = PH_STATUS;
            col_off_next = q_job.col_off;
            press_next   = q_job.press;
            rel_next     = q_job.release_m;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_STATUS;
            active_reg <= 1'b0;
            outv_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            active_reg <= active_next;
            outv_reg   <= outv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_off_reg <= col_off_next;
        press_reg   <= press_next;
        rel_reg     <= rel_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

endmodule

`default_nettype wire

// File: rtl/key_matrix_midi_note_events_top.sv
// Key matrix scan to MIDI note events: top level.
// Channels:
//   col  (sink)  : one scanned column per item, column_index and row_levels.
//   midi (source): one MIDI byte per item; last_byte marks the final byte
//                  caused by a column. Status 0x9n, note, velocity (0 = release).
//   cfg  (sink)  : register writes (0 channel, 1 lowest note, 2 press velocity);
//                  always ready, write only while no column is in flight.
// Path: the first byte of a changed column goes through the job queue, the
// back end's job registers and the output register. Bytes leave one per cycle
// while midi.ready is high, 3 per changed key, for k <= 4 changed keys per
// column; a column with no change or an out-of-range index produces nothing.
// Throughput is set by the single byte serializer in the back end; the
// two-entry job queue lets the front keep taking columns while the
// serializer drains.
// Stall: when midi.ready is low the output byte holds; the queue fills and
// then col.ready drops. No byte is lost or repeated.
// Reset: pressed-key map cleared (no key down), registers take channel 1,
// lowest note 41, velocity 127; queue and output stage empty.
`default_nettype none

module key_matrix_midi_note_events_top #(
    parameter int NUM_COLUMNS = 8,
    parameter int NUM_ROWS = 4
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kmme_col_if.sink    col,
    kmme_midi_if.source midi,
    kmme_cfg_if.sink    cfg
);

    // Configuration registers
    kmme_pkg::cfg_t cfg_reg, cfg_next;

    // Front to queue, queue to back
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    kmme_pkg::job_t push_job;
    kmme_pkg::job_t head_job;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                kmme_pkg::CFG_MIDI_CHANNEL:   cfg_next.midi_channel   = cfg.data[3:0];
                kmme_pkg::CFG_LOWEST_NOTE:    cfg_next.lowest_note    = cfg.data[6:0];
                kmme_pkg::CFG_PRESS_VELOCITY: cfg_next.press_velocity = cfg.data[6:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midi_channel   <= kmme_pkg::RST_MIDI_CHANNEL;
            cfg_reg.lowest_note    <= kmme_pkg::RST_LOWEST_NOTE;
            cfg_reg.press_velocity <= kmme_pkg::RST_PRESS_VELOCITY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each column against the pressed map
    kmme_front #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .col    (col),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (push_job)
    );

    // Decoupling queue
    kmme_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_job  (head_job)
    );

    // Back: byte serializer with output register
    kmme_back #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_regs (cfg_reg),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .midi     (midi)
    );

endmodule

`default_nettype wire

// File: rtl/kmme_checker.sv
// Port-level checker for the key matrix MIDI note event block, with bind.
// Depends on key_matrix_midi_note_events_top_assert.svh and kmme_pkg.
`default_nettype none

`include "key_matrix_midi_note_events_top_assert.svh"

module kmme_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] midi_byte,
    input wire logic       last_byte,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready
);

    // A stalled byte holds
    `KMME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(midi_byte) && $stable(last_byte), "stalled MIDI byte changed")

    // Only note-on status bytes have the top bit set
    `KMME_ASSERT_NOW(a_status_code, out_valid && midi_byte[7], midi_byte[7:4] == kmme_pkg::MIDI_NOTE_ON, "bad status byte")

    // The end-of-column flag sits on a data byte, never on a status byte
    `KMME_ASSERT_NOW(a_last_on_data, out_valid && last_byte, !midi_byte[7], "last flag on status byte")

    // Register writes are not stalled while the column channel is idle
    `KMME_ASSERT_NOW(a_cfg_ready, cfg_valid && !in_valid, cfg_ready, "config write stalled")

    // A column item that waits stays offered until it is taken
    `KMME_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid, "waiting column item withdrawn")

endmodule

bind key_matrix_midi_note_events_top kmme_checker u_kmme_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (col.valid),
    .in_ready  (col.ready),
    .out_valid (midi.valid),
    .out_ready (midi.ready),
    .midi_byte (midi.midi_byte),
    .last_byte (midi.last_byte),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

`default_nettype wire

// File: tb/testbench.sv
// Testbench for key_matrix_midi_note_events_top: scans columns, predicts MIDI bytes.
// Depends on kmme_pkg and the kmme_col_if, kmme_midi_if and kmme_cfg_if interfaces
// from the RTL.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmme_pkg::*;

    localparam int COLUMNS = 8;
    localparam int ROWS = 4;
    localparam int PHASES = 6;
    localparam int SCANS_PER_PHASE = 81;
    localparam int SETTLE_CYCLES = 24;      // well past the queue and output register path
    localparam int CYCLE_LIMIT = 400000;

    // One MIDI byte as it leaves the block
    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } midi_item_t;

    // One row of the directed scan table. When typed is set, the three bytes
    // of the single message this column causes are given here directly.
    typedef struct packed {
        logic [2:0] column;
        logic [3:0] rows;
        logic       typed;
        logic [7:0] status;
        logic [7:0] note;
        logic [7:0] velocity;
    } scan_row_t;

    localparam int DIRECTED_ROWS = 19;

    // Opening rows run at reset settings: channel 1, lowest note 41, velocity 127.
    scan_row_t directed_scans [DIRECTED_ROWS] = '{
        '{3'd1, 4'b0001, 1'b1, 8'h91, 8'd41, 8'd127},  // first press after reset
        '{3'd1, 4'b0000, 1'b1, 8'h91, 8'd41, 8'd0},    // its release, velocity zero
        '{3'd0, 4'b0001, 1'b1, 8'h91, 8'd48, 8'd127},  // column 0 maps to top of row
        '{3'd0, 4'b0000, 1'b1, 8'h91, 8'd48, 8'd0},
        '{3'd7, 4'b1000, 1'b1, 8'h91, 8'd71, 8'd127},  // top row, column 7
        '{3'd7, 4'b0000, 1'b1, 8'h91, 8'd71, 8'd0},
        '{3'd3, 4'b1111, 1'b0, 8'h00, 8'd0, 8'd0},     // four presses, twelve bytes
        '{3'd3, 4'b1111, 1'b0, 8'h00, 8'd0, 8'd0},     // no change, nothing out
        '{3'd3, 4'b0101, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd3, 4'b1010, 1'b0, 8'h00, 8'd0, 8'd0},     // presses first, then releases
        '{3'd3, 4'b0000, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd5, 4'b1111, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd6, 4'b0110, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd0, 4'b1111, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd5, 4'b0000, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd6, 4'b0000, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd0, 4'b0000, 1'b0, 8'h00, 8'd0, 8'd0},
        '{3'd2, 4'b1001, 1'b0, 8'h00, 8'd0, 8'd0},     // left held into the next phase
        '{3'd4, 4'b0100, 1'b0, 8'h00, 8'd0, 8'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    kmme_col_if  col_ch ();
    kmme_midi_if midi_ch ();
    kmme_cfg_if  cfg_ch ();

    key_matrix_midi_note_events_top #(
        .NUM_COLUMNS(COLUMNS),
        .NUM_ROWS(ROWS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .col(col_ch),
        .midi(midi_ch),
        .cfg(cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: its own copy of the registers and the pressed-key map
    logic [3:0] channel_reg;
    logic [6:0] lowest_note_reg;
    logic [6:0] velocity_reg;
    logic [3:0] keys_down [COLUMNS];

    midi_item_t pending_bytes [$];   // bytes still owed by the block, oldest first
    midi_item_t fresh_bytes [$];     // bytes of the column just predicted

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned columns_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned cfg_writes = 0;
    bit          no_idle = 1'b0;     // shared by both sides: stretches without gaps

    // Gap or stall length before the next item on either side
    function automatic int unsigned idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // Note of a key: column 0 sits at the top of its row.
    function automatic logic [6:0] note_of_key(input int row, input logic [2:0] column);
        logic [6:0] offset;
        offset = (column == 3'd0) ? 7'(COLUMNS - 1) : 7'(column - 3'd1);
        return lowest_note_reg + offset + 7'(COLUMNS * row);   // 7-bit wrap
    endfunction

    task automatic push_message(input logic [6:0] note, input logic [6:0] vel);
        fresh_bytes.push_back('{{MIDI_NOTE_ON, channel_reg}, 1'b0});
        fresh_bytes.push_back('{{1'b0, note}, 1'b0});
        fresh_bytes.push_back('{{1'b0, vel}, 1'b0});
    endtask

    // Presses in row order, then releases in row order; last flag on the final byte.
    task automatic predict_note_events(input logic [2:0] column, input logic [3:0] rows);
        fresh_bytes.delete();
        for (int g = 0; g < ROWS; g++)
        begin
            if (rows[g] && !keys_down[column][g])
            begin
                keys_down[column][g] = 1'b1;
                push_message(note_of_key(g, column), velocity_reg);
            end
        end
        for (int g = 0; g < ROWS; g++)
        begin
            if (!rows[g] && keys_down[column][g])
            begin
                keys_down[column][g] = 1'b0;
                push_message(note_of_key(g, column), 7'd0);
            end
        end
        if (fresh_bytes.size() > 0)
            fresh_bytes[fresh_bytes.size() - 1].last_byte = 1'b1;
    endtask

    // Offer one column after a random gap; on acceptance queue what it owes.
    task automatic send_column(input scan_row_t scan);
        int unsigned gap;
        gap = idle_cycles();
        repeat (gap)
        begin
            @(negedge clk);
            col_ch.valid <= 1'b0;
        end
        @(negedge clk);
        col_ch.valid        <= 1'b1;
        col_ch.column_index <= scan.column;
        col_ch.row_levels   <= scan.rows;
        do
            @(posedge clk);
        while (!(col_ch.valid && col_ch.ready));
        columns_sent++;
        predict_note_events(scan.column, scan.rows);
        if (scan.typed)
        begin
            pending_bytes.push_back('{scan.status, 1'b0});
            pending_bytes.push_back('{scan.note, 1'b0});
            pending_bytes.push_back('{scan.velocity, 1'b1});
        end
        else
        begin
            foreach (fresh_bytes[i])
                pending_bytes.push_back(fresh_bytes[i]);
        end
    endtask

    // Register write; unused high data bits are set at random since the
    // block keeps only the field's width.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = {1'($urandom_range(0, 1)), value};
        if (idx == CFG_MIDI_CHANNEL)
            data[6:4] = 3'($urandom_range(0, 7));
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_writes++;
        case (idx)
            CFG_MIDI_CHANNEL:   channel_reg = data[3:0];
            CFG_LOWEST_NOTE:    lowest_note_reg = data[6:0];
            CFG_PRESS_VELOCITY: velocity_reg = data[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Idle point: every owed byte out, then SETTLE_CYCLES more for columns that
    // cause nothing but may still be in the pipe.
    task automatic settle();
        @(negedge clk);
        col_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // MIDI sink: random stall before each byte, ready held until it moves.
    initial
    begin : midi_sink
        int unsigned stall;
        midi_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = idle_cycles();
            repeat (stall)
            begin
                @(negedge clk);
                midi_ch.ready <= 1'b0;
            end
            @(negedge clk);
            midi_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(midi_ch.valid && midi_ch.ready));
        end
    end

    // Byte checker: each accepted byte against the oldest expectation.
    always @(posedge clk)
    begin : midi_checker
        midi_item_t want;
        if (rst_n && midi_ch.valid && midi_ch.ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte: midi_byte %02h last_byte %0b",
                       midi_ch.midi_byte, midi_ch.last_byte);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (midi_ch.midi_byte !== want.midi_byte)
                begin
                    $error("midi_byte: expected %02h, got %02h",
                           want.midi_byte, midi_ch.midi_byte);
                    errors++;
                end
                if (midi_ch.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %0b, got %0b",
                           want.last_byte, midi_ch.last_byte);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a hang or a lost byte ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycles, pending_bytes.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        scan_row_t scan;
        logic [6:0] phase_cfg [3];
        int unsigned pick;

        // All inputs known from time zero
        rst_n = 1'b0;
        col_ch.valid = 1'b0;
        col_ch.column_index = '0;
        col_ch.row_levels = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_MIDI_CHANNEL;
        cfg_ch.data = '0;

        channel_reg = RST_MIDI_CHANNEL;
        lowest_note_reg = RST_LOWEST_NOTE;
        velocity_reg = RST_PRESS_VELOCITY;
        foreach (keys_down[c])
            keys_down[c] = '0;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table at reset settings
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_column(directed_scans[r]);
        settle();

        // Random phases; phase 0 keeps the reset settings, then the extremes,
        // a middle setting and two random ones. Keys held across a phase
        // boundary release under the new note mapping.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                case (phase)
                    1: phase_cfg = '{7'd15, 7'd95, 7'd127};
                    2: phase_cfg = '{7'd0, 7'd0, 7'd0};
                    3: phase_cfg = '{7'd7, 7'd64, 7'd1};
                    default: phase_cfg = '{7'($urandom_range(0, 15)),
                                           7'($urandom_range(0, 95)),
                                           7'($urandom_range(0, 127))};
                endcase
                write_register(CFG_MIDI_CHANNEL, phase_cfg[0]);
                write_register(CFG_LOWEST_NOTE, phase_cfg[1]);
                write_register(CFG_PRESS_VELOCITY, phase_cfg[2]);
            end
            for (int i = 0; i < SCANS_PER_PHASE; i++)
            begin
                // About one stretch in four runs both sides with no gaps
                if (i % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                scan = '0;
                scan.column = 3'($urandom_range(0, COLUMNS - 1));
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    scan.rows = keys_down[scan.column];        // nothing changes
                else if (pick < 25)
                    scan.rows = (pick < 20) ? 4'b1111 : 4'b0000;
                else
                    scan.rows = 4'($urandom_range(0, 15));
                send_column(scan);
            end
            settle();
        end

        $display("summary: %0d columns scanned over %0d settings, %0d config writes",
                 columns_sent, PHASES, cfg_writes);
        $display("summary: %0d MIDI bytes checked, %0d mismatches", bytes_checked, errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
